FILE: rtl/ow_pkg.sv
// Package: shared types, codes, and helpers of the 1-Wire bus master.
`default_nettype none
package ow_pkg;

  localparam int COUNT_W = 10;
  localparam int LIM_W = 10;
  localparam int CMP_W = (COUNT_W > LIM_W) ? COUNT_W : LIM_W;

  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_RESET = 3'd1;
  localparam logic [2:0] FN_WBYTE = 3'd2;
  localparam logic [2:0] FN_RBYTE = 3'd3;
  localparam logic [2:0] FN_WBIT  = 3'd4;
  localparam logic [2:0] FN_RBIT  = 3'd5;

  localparam logic [2:0] RI_RESET_LOW   = 3'd0;
  localparam logic [2:0] RI_PRES_WAIT   = 3'd1;
  localparam logic [2:0] RI_RESET_REC   = 3'd2;
  localparam logic [2:0] RI_SHORT_LOW   = 3'd3;
  localparam logic [2:0] RI_READ_SAMPLE = 3'd4;
  localparam logic [2:0] RI_SLOT_LEN    = 3'd5;
  localparam logic [2:0] RI_ZERO_LOW    = 3'd6;
  localparam logic [2:0] RI_BIT_GAP     = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PRES  = 2'd1;
  localparam logic [1:0] ST_BUS_ERR  = 2'd2;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_RLOW  = 8'b0000_0010,
    PH_RWAIT = 8'b0000_0100,
    PH_RREC  = 8'b0000_1000,
    PH_SLOW  = 8'b0001_0000,
    PH_SREL  = 8'b0010_0000,
    PH_SFILL = 8'b0100_0000,
    PH_GAP   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] presence_wait;
    logic [9:0] reset_recovery;
    logic [5:0] short_low_time;
    logic [5:0] read_sample_wait;
    logic [7:0] slot_length;
    logic [7:0] write_zero_low_time;
    logic [3:0] bit_gap;
  } ow_cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [COUNT_W-1:0]   tick_count;
    logic [2:0]           bit_index;
    logic [7:0]           shift_byte;
    logic [2:0]           command_kind;
    logic [1:0]           presence_flag;
  } ow_state_t;

  typedef struct packed {
    logic       rejected;
    logic [1:0] status;
    logic [7:0] rx_data;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } ow_res_t;

  function automatic logic [LIM_W-1:0] at_least_one(input logic [LIM_W-1:0] v);
    return (v == '0) ? LIM_W'(1) : v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ow_cfg.sv
// Timing configuration registers of the 1-Wire bus master.
`default_nettype none
module ow_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [9:0]    cfg_data,
  output ow_pkg::ow_cfg_t    cfg
);
  import ow_pkg::*;

  ow_cfg_t cfg_r;
  ow_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        RI_RESET_LOW:   cfg_nxt.reset_low_time = cfg_data;
        RI_PRES_WAIT:   cfg_nxt.presence_wait = cfg_data[7:0];
        RI_RESET_REC:   cfg_nxt.reset_recovery = cfg_data;
        RI_SHORT_LOW:   cfg_nxt.short_low_time = cfg_data[5:0];
        RI_READ_SAMPLE: cfg_nxt.read_sample_wait = cfg_data[5:0];
        RI_SLOT_LEN:    cfg_nxt.slot_length = cfg_data[7:0];
        RI_ZERO_LOW:    cfg_nxt.write_zero_low_time = cfg_data[7:0];
        RI_BIT_GAP:     cfg_nxt.bit_gap = cfg_data[3:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time      <= 10'd480;
      cfg_r.presence_wait       <= 8'd70;
      cfg_r.reset_recovery      <= 10'd410;
      cfg_r.short_low_time      <= 6'd6;
      cfg_r.read_sample_wait    <= 6'd9;
      cfg_r.slot_length         <= 8'd70;
      cfg_r.write_zero_low_time <= 8'd60;
      cfg_r.bit_gap             <= 4'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ow_step.sv
// Next-state and result logic for one item of the 1-Wire bus master.
`default_nettype none
module ow_step (
  input  wire ow_pkg::ow_cfg_t   cfg,
  input  wire ow_pkg::ow_state_t cur,
  input  wire logic [2:0]        func,
  input  wire logic [7:0]        tx_data,
  input  wire logic              line_level,
  output ow_pkg::ow_state_t      nxt,
  output ow_pkg::ow_res_t        res
);
  import ow_pkg::*;

  localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

  logic [COUNT_W-1:0] tc_inc;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W-1:0]   low_len;
  logic [LIM_W-1:0]   rsw_len;
  logic [8:0]         used;
  logic [7:0]         fill_len;
  logic               is_read;
  logic               ended;
  logic               do_fill;
  logic               do_after;
  logic               do_next;
  logic               fin;
  ow_state_t          n;
  ow_res_t            r;

  always_comb begin
    is_read = (cur.command_kind == FN_RBYTE) || (cur.command_kind == FN_RBIT);
    rsw_len = at_least_one(LIM_W'(cfg.read_sample_wait));
    if (!is_read && !cur.shift_byte[0]) begin
      low_len = at_least_one(LIM_W'(cfg.write_zero_low_time));
    end else begin
      low_len = at_least_one(LIM_W'(cfg.short_low_time));
    end
    used = 9'(low_len) + (is_read ? 9'(rsw_len) : 9'd0);
    fill_len = (9'(cfg.slot_length) > used) ? 8'(9'(cfg.slot_length) - used) : 8'd0;
    tc_inc = (cur.tick_count < CNT_MAX) ? cur.tick_count + 1'b1 : cur.tick_count;

    case (cur.phase)
      PH_RLOW:  lim = at_least_one(cfg.reset_low_time);
      PH_RWAIT: lim = at_least_one(LIM_W'(cfg.presence_wait));
      PH_RREC:  lim = at_least_one(cfg.reset_recovery);
      PH_SLOW:  lim = low_len;
      PH_SREL:  lim = rsw_len;
      PH_SFILL: lim = LIM_W'(fill_len);
      PH_GAP:   lim = at_least_one(LIM_W'(cfg.bit_gap));
      default:  lim = '0;
    endcase
    ended = (CMP_W'(tc_inc) >= CMP_W'(lim)) || (tc_inc == CNT_MAX);

    n = cur;
    r = '0;
    do_fill = 1'b0;
    do_after = 1'b0;
    do_next = 1'b0;
    fin = 1'b0;

    if (func inside {FN_RESET, FN_WBYTE, FN_RBYTE, FN_WBIT, FN_RBIT}) begin
      if (cur.phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        n.command_kind = func;
        n.tick_count = '0;
        n.bit_index = '0;
        if (func == FN_RESET) begin
          n.phase = PH_RLOW;
          n.presence_flag = ST_OK;
        end else begin
          n.phase = PH_SLOW;
          if (func == FN_WBIT) begin
            n.shift_byte = {7'd0, tx_data[0]};
          end else if (func == FN_WBYTE) begin
            n.shift_byte = tx_data;
          end else begin
            n.shift_byte = '0;
          end
        end
      end
    end else if (func == FN_TICK && cur.phase != PH_IDLE) begin
      n.tick_count = tc_inc;
      if (ended) begin
        n.tick_count = '0;
        case (cur.phase)
          PH_RLOW: n.phase = PH_RWAIT;
          PH_RWAIT: begin
            n.presence_flag = line_level ? ST_NO_PRES : ST_OK;
            n.phase = PH_RREC;
          end
          PH_RREC: begin
            if (!line_level) begin
              n.presence_flag = ST_BUS_ERR;
            end
            r.status = n.presence_flag;
            fin = 1'b1;
          end
          PH_SLOW: begin
            if (is_read) begin
              n.phase = PH_SREL;
            end else begin
              do_fill = 1'b1;
            end
          end
          PH_SREL: begin
            n.shift_byte = {line_level, cur.shift_byte[7:1]};
            do_fill = 1'b1;
          end
          PH_SFILL: do_after = 1'b1;
          PH_GAP:   do_next = 1'b1;
          default:  n.phase = PH_IDLE;
        endcase

        if (do_fill) begin
          if (fill_len == 8'd0) begin
            do_after = 1'b1;
          end else begin
            n.phase = PH_SFILL;
          end
        end
        if (do_after) begin
          if (cur.command_kind == FN_WBIT || cur.command_kind == FN_RBIT) begin
            fin = 1'b1;
          end else begin
            if (cur.command_kind == FN_WBYTE) begin
              n.shift_byte = {1'b0, n.shift_byte[7:1]};
            end
            if (cfg.bit_gap != 4'd0) begin
              n.phase = PH_GAP;
            end else begin
              do_next = 1'b1;
            end
          end
        end
        if (do_next) begin
          if (cur.bit_index == 3'd7) begin
            fin = 1'b1;
          end else begin
            n.bit_index = cur.bit_index + 3'd1;
            n.phase = PH_SLOW;
          end
        end
        if (fin) begin
          n.phase = PH_IDLE;
          n.tick_count = '0;
          r.done_res = 1'b1;
          if (cur.command_kind == FN_RBYTE) begin
            r.rx_data = n.shift_byte;
          end else if (cur.command_kind == FN_RBIT) begin
            r.rx_data = {7'd0, n.shift_byte[7]};
          end
        end
      end
    end else if (func == FN_TICK && cur.phase == PH_IDLE) begin
      n = cur;
    end

    r.drive_low = (n.phase == PH_RLOW) || (n.phase == PH_SLOW);
    r.busy_res = (n.phase != PH_IDLE);
    nxt = n;
    res = r;
  end

endmodule
`default_nettype wire

FILE: rtl/one_wire_bus_master_core.sv
// Top level of the 1-Wire bus master: input register, state, and result register.
// The core takes one beat per clock whenever the result side keeps taking beats,
// either a command or a microsecond tick carrying the sampled bus level, and
// returns exactly one result beat for each input beat, in order. A beat is
// registered in the input register on entry, the timing state machine advances
// once the output register is free, and the result lands in the output register,
// where it is offered. The output register frees as it is read, so a new beat is
// taken in the same clock that a waiting result leaves. Timing registers are
// written through the configuration channel, which is always ready, and should
// only change while the bus is idle.
`default_nettype none
module one_wire_bus_master_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // tx_data [7:0], line_level [8], zero [15:9]
  input  wire logic [2:0]  in_tuser,   // func [2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // drive_low [0], busy_res [1], done_res [2],
                                       // rx_data [10:3], status [12:11], rejected [13],
                                       // zero [15:14]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import ow_pkg::*;

  ow_cfg_t   cfg;
  ow_state_t state_r;
  ow_state_t state_nxt;
  ow_res_t   res_nxt;
  ow_res_t   res_r;
  logic      in_v_r;
  logic [2:0] func_r;
  logic [7:0] tx_r;
  logic      line_r;
  logic      out_v_r;
  logic      advance;

  ow_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ow_step u_step (
    .cfg        (cfg),
    .cur        (state_r),
    .func       (func_r),
    .tx_data    (tx_r),
    .line_level (line_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign out_tvalid = out_v_r;
  assign out_tdata = {2'b00, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r <= in_tuser;
      tx_r   <= in_tdata[7:0];
      line_r <= in_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_IDLE;
      state_r.tick_count    <= '0;
      state_r.bit_index     <= '0;
      state_r.shift_byte    <= '0;
      state_r.command_kind  <= '0;
      state_r.presence_flag <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.rejected) |-> res_r.busy_res)
    else $error("rejected command reported while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.done_res) |-> !res_r.busy_res)
    else $error("completion reported while still busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.drive_low) |-> res_r.busy_res)
    else $error("bus driven low while idle");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && $past(rst_n)) |=> $stable(state_r))
    else $error("state changed without an item");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.status != ST_OK) |-> res_r.done_res)
    else $error("status reported without completion");

endmodule
`default_nettype wire
